// ===== hdl/xmbt_pkg.sv =====
// shared types and constants of the xor-metric bucket table
package xmbt_pkg;

	localparam int ID_W      = 160;
	localparam int CONTACT_W = 64;
	localparam int ENTRY_W   = ID_W + CONTACT_W;
	localparam int BYTE_W    = 8;
	localparam int NBYTES    = 20;
	localparam int BUCKET_W  = 8;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_ADDED     = 4'd0,
		ST_UPDATED   = 4'd1,
		ST_FULL      = 4'd2,
		ST_OWN_ID    = 4'd3,
		ST_RANGE     = 4'd4,
		ST_REMOVED   = 4'd5,
		ST_ABSENT    = 4'd6,
		ST_FOUND     = 4'd7,
		ST_NOT_FOUND = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		SEL_IDX  = 2'd0,
		SEL_NEXT = 2'd1,
		SEL_FILL = 2'd2
	} addr_sel_t;

	typedef enum logic [1:0] {
		REG_OWN_UPPER  = 2'd0,
		REG_OWN_MIDDLE = 2'd1,
		REG_OWN_LOWER  = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic      capture;
		logic      bkt_load;
		logic      fill_rd;
		logic      idx_clr;
		logic      idx_inc;
		logic      slot_rd;
		logic      slot_wr;
		addr_sel_t addr_sel;
		logic      wr_move;
		logic      fill_inc;
		logic      fill_dec;
		logic      out_load;
		status_t   code;
	} cmd_t;

	typedef struct packed {
		logic    own;
		logic    oor;
		logic    fill_full;
		logic    idx_end;
		logic    last;
		logic    match;
		action_t action;
		logic    out_free;
	} sts_t;

endpackage

// ===== hdl/xmbt_ctrl.sv =====
// request sequencer of the xor-metric bucket table
module xmbt_ctrl import xmbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_BKT  = 9'b000000010,
		S_CHK  = 9'b000000100,
		S_SCAN = 9'b000001000,
		S_CMP  = 9'b000010000,
		S_ACT  = 9'b000100000,
		S_SHRD = 9'b001000000,
		S_SHWR = 9'b010000000,
		S_RESP = 9'b100000000
	} state_t;

	state_t  state_q, state_nx;
	status_t code_q, code_nx;
	logic    hit_q, hit_nx;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		code_nx  = code_q;
		hit_nx   = hit_q;
		cmd      = '0;
		cmd.addr_sel = SEL_IDX;
		cmd.code     = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_BKT;
				end
			end
			S_BKT: begin
				cmd.bkt_load = 1'b1;
				state_nx     = S_CHK;
			end
			S_CHK: begin
				hit_nx = 1'b0;
				if (sts.own) begin
					code_nx  = ST_OWN_ID;
					state_nx = S_RESP;
				end else if (sts.oor) begin
					code_nx  = ST_RANGE;
					state_nx = S_RESP;
				end else begin
					cmd.fill_rd = 1'b1;
					cmd.idx_clr = 1'b1;
					state_nx    = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.idx_end) begin
					state_nx = S_ACT;
				end else begin
					cmd.slot_rd = 1'b1;
					state_nx    = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.match) begin
					hit_nx   = 1'b1;
					state_nx = S_ACT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_SCAN;
				end
			end
			S_ACT: begin
				state_nx = S_RESP;
				unique case (sts.action)
					ACT_ADD: begin
						if (hit_q) begin
							cmd.slot_wr = 1'b1;
							code_nx     = ST_UPDATED;
						end else if (!sts.fill_full) begin
							cmd.slot_wr  = 1'b1;
							cmd.addr_sel = SEL_FILL;
							cmd.fill_inc = 1'b1;
							code_nx      = ST_ADDED;
						end else begin
							code_nx = ST_FULL;
						end
					end
					ACT_REMOVE: begin
						if (hit_q) begin
							state_nx = S_SHRD;
						end else begin
							code_nx = ST_ABSENT;
						end
					end
					ACT_LOOKUP, ACT_SPARE: begin
						code_nx = hit_q ? ST_FOUND : ST_NOT_FOUND;
					end
					default: code_nx = ST_NOT_FOUND;
				endcase
			end
			S_SHRD: begin
				if (sts.last) begin
					cmd.fill_dec = 1'b1;
					code_nx      = ST_REMOVED;
					state_nx     = S_RESP;
				end else begin
					cmd.slot_rd  = 1'b1;
					cmd.addr_sel = SEL_NEXT;
					state_nx     = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.slot_wr = 1'b1;
				cmd.wr_move = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nx    = S_SHRD;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_ADDED;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			code_q  <= code_nx;
			hit_q   <= hit_nx;
		end
	end

endmodule

// ===== hdl/xmbt_dp.sv =====
// datapath of the xor-metric bucket table: distance, bucket index, slot and fill stores
module xmbt_dp import xmbt_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int NUM_BUCKETS      = 160
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [1:0]           action,
	input  logic [ID_W-1:0]      key,
	input  logic [CONTACT_W-1:0] contact_in,
	input  logic [ID_W-1:0]      own_id,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [3:0]           status,
	output logic [BUCKET_W-1:0]  bucket_number,
	output logic [CONTACT_W-1:0] contact_out
);

	localparam int TOTAL  = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int IDX_W  = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BKT_AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	logic [ID_W-1:0]      key_q;
	logic [CONTACT_W-1:0] contact_q;
	action_t              action_q;
	logic [ID_W-1:0]      dist_q;
	logic [BUCKET_W-1:0]  bucket_q;
	logic                 own_q;
	logic                 oor_q;
	logic [ADDR_W-1:0]    base_q;
	logic [IDX_W-1:0]     fill_rd_q;
	logic                 fvld_rd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [ENTRY_W-1:0]   rd_q;
	logic                 out_valid_q;
	status_t              status_q;
	logic [BUCKET_W-1:0]  bucket_out_q;
	logic [CONTACT_W-1:0] contact_out_q;

	logic [ENTRY_W-1:0]   slot_mem [TOTAL];
	logic [IDX_W-1:0]     fill_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] fill_vld_q;

	logic [NBYTES-1:0]    byte_nz;
	logic [4:0]           byte_hi;
	logic [BYTE_W-1:0]    byte_sel;
	logic [2:0]           bit_hi;
	logic [BUCKET_W-1:0]  bucket_nx;
	logic [IDX_W-1:0]     fill_eff;
	logic [IDX_W:0]       idx_p1;
	logic [ADDR_W-1:0]    addr;
	logic [BKT_AW-1:0]    bidx;
	logic [ENTRY_W-1:0]   wr_data;

	// highest set bit of the distance: a byte first, then a bit in it
	always_comb begin
		byte_hi = '0;
		for (int k = 0; k < NBYTES; k++) begin
			byte_nz[k] = |dist_q[k*BYTE_W +: BYTE_W];
			if (byte_nz[k]) byte_hi = 5'(k);
		end
		byte_sel = dist_q[byte_hi*BYTE_W +: BYTE_W];
		bit_hi   = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			if (byte_sel[b]) bit_hi = 3'(b);
		end
		bucket_nx = {byte_hi, bit_hi};
	end

	assign bidx     = bucket_q[BKT_AW-1:0];
	assign fill_eff = fvld_rd_q ? fill_rd_q : '0;
	assign idx_p1   = {1'b0, idx_q} + 1'b1;

	always_comb begin
		case (cmd.addr_sel)
			SEL_NEXT: addr = base_q + ADDR_W'(idx_p1);
			SEL_FILL: addr = base_q + ADDR_W'(fill_eff);
			default:  addr = base_q + ADDR_W'(idx_q);
		endcase
	end

	assign wr_data = cmd.wr_move ? rd_q : {key_q, contact_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q     <= key;
			contact_q <= contact_in;
			action_q  <= action_t'(action);
			dist_q    <= key ^ own_id;
		end
		if (cmd.bkt_load) begin
			bucket_q <= bucket_nx;
			own_q    <= (dist_q == '0) && (action_q == ACT_ADD);
			oor_q    <= (32'(bucket_nx) >= NUM_BUCKETS);
			base_q   <= ADDR_W'(ADDR_W'(bucket_nx) * ADDR_W'(SLOTS_PER_BUCKET));
		end
		if (cmd.fill_rd) begin
			fill_rd_q <= fill_mem[bidx];
			fvld_rd_q <= fill_vld_q[bidx];
		end
		if (cmd.fill_inc) fill_mem[bidx] <= fill_eff + 1'b1;
		if (cmd.fill_dec) fill_mem[bidx] <= fill_eff - 1'b1;
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1[IDX_W-1:0];
		end
		if (cmd.slot_rd) rd_q <= slot_mem[addr];
		if (cmd.slot_wr) slot_mem[addr] <= wr_data;
		if (cmd.out_load) begin
			status_q      <= cmd.code;
			bucket_out_q  <= bucket_q;
			contact_out_q <= (cmd.code == ST_FOUND) ? rd_q[CONTACT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_inc || cmd.fill_dec) fill_vld_q[bidx] <= 1'b1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.own       = own_q;
	assign sts.oor       = oor_q;
	assign sts.fill_full = (32'(fill_eff) >= SLOTS_PER_BUCKET);
	assign sts.idx_end   = (idx_q >= fill_eff);
	assign sts.last      = (idx_p1 >= {1'b0, fill_eff});
	assign sts.match     = (rd_q[ENTRY_W-1:CONTACT_W] == key_q);
	assign sts.action    = action_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign bucket_number = bucket_out_q;
	assign contact_out   = contact_out_q;

endmodule

// ===== hdl/xor_metric_bucket_table.sv =====
// top level of the xor-metric bucket table with its configuration port
// A routing table of node contacts sorted into buckets by xor distance from this
// node's own id. Each request transfer carries an action (add, remove, look up), a
// 160-bit node id and a 64-bit contact; each one yields exactly one result transfer
// with a status, the bucket number and, for a successful lookup, the stored contact.
// Requests are handled one at a time by a sequencer over a single-port slot memory:
// it takes in the request transfer, loads the bucket index and reads the fill count,
// then reads and compares the slots one at a time until a match or the end of the
// scan, acts and loads the result; a remove first moves every later slot down one
// place and updates the fill count. A request ends early on an add of the own id
// or on a bucket out of range, and a stalled result holds the sequencer until taken.
// Fill counts start at zero after reset with no clearing pass. The own id registers
// lie at byte addresses 0, 8 and 16 and are only to be written while no request is
// in flight.
module xor_metric_bucket_table import xmbt_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int NUM_BUCKETS      = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key_upper,
	input  logic [63:0] key_middle,
	input  logic [31:0] key_lower,
	input  logic [63:0] contact_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [7:0]  bucket_number,
	output logic [63:0] contact_out
);

	logic [63:0] own_upper_q;
	logic [63:0] own_middle_q;
	logic [31:0] own_lower_q;
	reg_idx_t    reg_sel;
	logic        reg_wr;
	cmd_t        cmd;
	sts_t        sts;

	// register decode: one register every 8 bytes, 64 bits wide but the lower one of 32
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:3]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_upper_q  <= '0;
			own_middle_q <= '0;
			own_lower_q  <= '0;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_OWN_UPPER:  own_upper_q  <= pwdata;
				REG_OWN_MIDDLE: own_middle_q <= pwdata;
				REG_OWN_LOWER:  own_lower_q  <= pwdata[31:0];
				REG_NONE:       ;
				default:        ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_OWN_UPPER:  prdata = own_upper_q;
			REG_OWN_MIDDLE: prdata = own_middle_q;
			REG_OWN_LOWER:  prdata = {32'd0, own_lower_q};
			default:        prdata = '0;
		endcase
	end

	// sequencer: one request at a time
	xmbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: bucket index, slot scan, compaction and result register
	xmbt_dp #(
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.NUM_BUCKETS      (NUM_BUCKETS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.key           ({key_upper, key_middle, key_lower}),
		.contact_in    (contact_in),
		.own_id        ({own_upper_q, own_middle_q, own_lower_q}),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.bucket_number (bucket_number),
		.contact_out   (contact_out)
	);

	// a contact only leaves the block on a successful lookup
	a_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FOUND) |-> contact_out == '0)
		else $error("contact_out not zero outside a found result");

	// the own id always sits at distance zero
	a_own_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OWN_ID) |-> bucket_number == '0)
		else $error("own id result with nonzero bucket");

	// out of range is only reported for buckets past the table
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_RANGE) |-> 32'(bucket_number) >= NUM_BUCKETS)
		else $error("out of range result for a bucket inside the table");

	// a request transfer makes the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

endmodule

// ===== sim/xmbt_checker.sv =====
// request and result monitor with bucket table predictor and result comparison
module xmbt_checker import xmbt_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int NUM_BUCKETS      = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key_upper,
	input  logic [63:0] key_middle,
	input  logic [31:0] key_lower,
	input  logic [63:0] contact_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  status,
	input  logic [7:0]  bucket_number,
	input  logic [63:0] contact_out,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     st;
		logic [7:0]  bkt;
		logic [63:0] contact;
	} table_result_t;

	logic [ID_W-1:0]      own_id;
	int                   fill_count [NUM_BUCKETS];
	logic [ID_W-1:0]      slot_id    [NUM_BUCKETS][SLOTS_PER_BUCKET];
	logic [CONTACT_W-1:0] slot_ct    [NUM_BUCKETS][SLOTS_PER_BUCKET];
	table_result_t        expected_results [$];

	function automatic int xor_bucket(logic [ID_W-1:0] key);
		logic [ID_W-1:0] xdist;
		int pos;
		xdist = key ^ own_id;
		pos = 0;
		for (int b = 0; b < ID_W; b++)
			if (xdist[b]) pos = b;
		return pos;
	endfunction

	function automatic table_result_t apply_request(action_t act, logic [ID_W-1:0] key,
			logic [CONTACT_W-1:0] ct);
		table_result_t r;
		int b, n, hit_at;
		b = xor_bucket(key);
		r.bkt = b[7:0];
		r.contact = '0;
		hit_at = -1;
		if (act == ACT_ADD && key == own_id) begin
			r.st = ST_OWN_ID;
			return r;
		end
		if (b >= NUM_BUCKETS) begin
			r.st = ST_RANGE;
			return r;
		end
		n = fill_count[b];
		for (int i = 0; i < n; i++)
			if (hit_at < 0 && slot_id[b][i] == key) hit_at = i;
		case (act)
			ACT_ADD: begin
				if (hit_at >= 0) begin
					slot_ct[b][hit_at] = ct;
					r.st = ST_UPDATED;
				end else if (n < SLOTS_PER_BUCKET) begin
					slot_id[b][n] = key;
					slot_ct[b][n] = ct;
					fill_count[b] = n + 1;
					r.st = ST_ADDED;
				end else begin
					r.st = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				if (hit_at >= 0) begin
					for (int j = hit_at; j + 1 < n; j++) begin
						slot_id[b][j] = slot_id[b][j+1];
						slot_ct[b][j] = slot_ct[b][j+1];
					end
					fill_count[b] = n - 1;
					r.st = ST_REMOVED;
				end else begin
					r.st = ST_ABSENT;
				end
			end
			default: begin
				if (hit_at >= 0) begin
					r.contact = slot_ct[b][hit_at];
					r.st = ST_FOUND;
				end else begin
					r.st = ST_NOT_FOUND;
				end
			end
		endcase
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			own_id = '0;
			foreach (fill_count[i]) fill_count[i] = 0;
			expected_results.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:3]))
					REG_OWN_UPPER:  own_id[159:96] = pwdata;
					REG_OWN_MIDDLE: own_id[95:32]  = pwdata;
					REG_OWN_LOWER:  own_id[31:0]   = pwdata[31:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					apply_request(action_t'(action),
					{key_upper, key_middle, key_lower}, contact_in));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, got status %0d bucket %0d",
						$time, status, bucket_number);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st) begin
						errors++;
						$display("%0t status mismatch: expected %0d, got %0d",
							$time, want.st, status);
					end
					if (bucket_number !== want.bkt) begin
						errors++;
						$display("%0t bucket mismatch: expected %0d, got %0d",
							$time, want.bkt, bucket_number);
					end
					if (contact_out !== want.contact) begin
						errors++;
						$display("%0t contact mismatch: expected %h, got %h",
							$time, want.contact, contact_out);
					end
				end
			end
		end
	end

endmodule

// ===== sim/xor_metric_bucket_table_test.sv =====
// stimulus, receiver stalls, watchdog and verdict for the xor-metric bucket table
module xor_metric_bucket_table_test import xmbt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_PER_SET = 385;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        in_valid, in_stall;
	logic [1:0]  action;
	logic [63:0] key_upper, key_middle, contact_in;
	logic [31:0] key_lower;
	logic        out_valid, out_stall;
	logic [3:0]  status;
	logic [7:0]  bucket_number;
	logic [63:0] contact_out;
	int          errors, pending, results_seen;

	// stimulus knobs and state; the hold and quiet flags are shared with the receiver process
	logic        hold_req, hold_done;
	logic        quiet_mode;
	int          requests_sent;
	logic [ID_W-1:0] own_id;
	logic [ID_W-1:0] key_pool [48];

	xor_metric_bucket_table dut (.*);

	xmbt_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// all inputs known from time zero, reset held low from the start and then released
	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; action = ACT_ADD;
		key_upper = '0; key_middle = '0; key_lower = '0; contact_in = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side: random stall runs, mostly short; one long hold on request
	initial begin
		int run_left;
		logic stalling;
		out_stall = 1'b0;
		hold_done = 1'b0;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				// long hold so the table backs up and stalls the request side
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					stalling = quiet_mode ? 1'b0 : ($urandom_range(0, 2) == 0);
					run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 6);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	// watchdog: cycles with no transfer on either channel and no register access
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles = 0;
			else if (arst_n)
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles, %0d results pending",
					idle_cycles, pending);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_own_id(logic [ID_W-1:0] id);
		write_reg(REG_OWN_UPPER, id[159:96]);
		write_reg(REG_OWN_MIDDLE, id[95:32]);
		write_reg(REG_OWN_LOWER, {32'd0, id[31:0]});
		own_id = id;
	endtask

	// sender pause until the table has answered everything
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_request(action_t act, logic [ID_W-1:0] key, logic [63:0] ct);
		int gap;
		gap = 0;
		if (!quiet_mode && $urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		{key_upper, key_middle, key_lower} <= key;
		contact_in <= ct;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	function automatic logic [ID_W-1:0] random_id();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// an id whose xor distance from the own id has its top bit at position b
	function automatic logic [ID_W-1:0] id_in_bucket(int b);
		logic [ID_W-1:0] xdist;
		xdist = random_id();
		for (int i = b; i < ID_W; i++) xdist[i] = 1'b0;
		xdist[b] = 1'b1;
		return own_id ^ xdist;
	endfunction

	function automatic logic [63:0] random_contact();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// pool crowded into four buckets so they fill, overflow and get compacted
	task automatic build_pool();
		int hot [4];
		hot[0] = $urandom_range(3, 20);
		hot[1] = $urandom_range(28, 40);
		hot[2] = $urandom_range(90, 100);
		hot[3] = $urandom_range(150, 159);
		foreach (key_pool[i]) key_pool[i] = id_in_bucket(hot[$urandom_range(0, 3)]);
	endtask

	task automatic random_phase(int count);
		action_t act;
		logic [ID_W-1:0] key;
		int pick;
		build_pool();
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) act = ACT_ADD;
			else if (pick < 70) act = ACT_REMOVE;
			else if (pick < 95) act = ACT_LOOKUP;
			else act = ACT_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 80) key = key_pool[$urandom_range(0, 47)];
			else if (pick < 88) key = own_id;
			else if (pick < 92) key = id_in_bucket($urandom_range(0, 2));
			else key = random_id();
			send_request(act, key, random_contact());
			// quiet stretches with no gaps on either side
			if (n % 100 == 0) quiet_mode = ~quiet_mode;
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		hold_req = 1'b0;
		quiet_mode = 1'b0;
		requests_sent = 0;
		own_id = '0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: own id all zero after reset
		send_request(ACT_LOOKUP, '1, '0);
		send_request(ACT_ADD, '1, '1);
		send_request(ACT_LOOKUP, '1, '0);
		send_request(ACT_ADD, '1, 64'h0123_4567_89ab_cdef);
		send_request(ACT_SPARE, '1, '1);
		send_request(ACT_REMOVE, '1, '0);
		send_request(ACT_REMOVE, '1, '0);
		// own id: add rejected, remove and lookup act as bucket zero
		send_request(ACT_ADD, '0, '1);
		send_request(ACT_LOOKUP, '0, '0);
		send_request(ACT_REMOVE, '0, '0);
		send_request(ACT_ADD, 160'd1, '1);
		send_request(ACT_LOOKUP, 160'd1, '0);
		// fill bucket 5 past capacity, then remove from the middle
		for (int i = 0; i < 9; i++)
			send_request(ACT_ADD, 160'd32 + i, 64'd100 + i);
		send_request(ACT_REMOVE, 160'd34, '0);
		send_request(ACT_LOOKUP, 160'd37, '0);
		send_request(ACT_ADD, 160'd40, '1);
		send_request(ACT_LOOKUP, 160'd40, '0);
		drain_results();

		// all-ones own id, with a long hold on the result side
		set_own_id('1);
		hold_req <= 1'b1;
		random_phase(RANDOM_PER_SET);
		drain_results();

		set_own_id(random_id());
		random_phase(RANDOM_PER_SET);
		drain_results();

		set_own_id({64'd0, 64'd0, 32'hffff_ffff});
		random_phase(RANDOM_PER_SET);
		drain_results();

		set_own_id('0);
		random_phase(RANDOM_PER_SET);
		drain_results();

		$display("covered %0d requests and %0d results over five own id settings",
			requests_sent, results_seen);
		$display("buckets were filled to overflow, compacted by removes and probed by lookups");
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
